// ===== sv/rtp_talkspurt_loss_monitor_assert.svh =====
// ---------------------------------------------------------------------------
// RTP talkspurt monitor assertion macros
// Shared concurrent assertion forms used by the monitor's modules.
// ---------------------------------------------------------------------------
`ifndef RTP_TALKSPURT_LOSS_MONITOR_ASSERT_SVH
`define RTP_TALKSPURT_LOSS_MONITOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RTM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rtm_pkg.sv =====
// ---------------------------------------------------------------------------
// RTP talkspurt monitor package
// Field widths, register map, reset values and the queue entry type.
// ---------------------------------------------------------------------------
package rtm_pkg;

    localparam int SEQ_W   = 16;
    localparam int BYTES_W = 16;
    localparam int TIME_W  = 32;
    localparam int GAP_W   = 16;
    localparam int LOST_W  = 15;
    localparam int CNT_W   = 32;
    localparam int BCNT_W  = 48;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [GAP_W-1:0] GAP_MS_RESET = 16'd200;
    localparam logic [SEQ_W-1:0] SEQ_HALF     = 16'h8000;

    // Register index, taken from paddr[2].
    localparam logic REG_GAP_MS         = 1'b0;
    localparam logic REG_REQUIRE_MARKER = 1'b1;

    typedef enum logic [1:0] {
        OP_IGNORE = 2'd0,
        OP_PACKET = 2'd1,
        OP_CLEAR  = 2'd2
    } rtm_op_t;

    typedef struct packed {
        rtm_op_t             op;
        logic [SEQ_W-1:0]    seq;
        logic                marker;
        logic [BYTES_W-1:0]  bytes;
        logic [TIME_W-1:0]   arrival;
    } rtm_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rtm_q_stat_t;

endpackage

// ===== sv/rtm_pkt_if.sv =====
// ---------------------------------------------------------------------------
// RTP packet header channel
// Valid/ready channel carrying one parsed RTP header or a clear request.
// ---------------------------------------------------------------------------
interface rtm_pkt_if import rtm_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               action;
    logic               header_ok;
    logic [SEQ_W-1:0]   sequence_req;
    logic               marker;
    logic [BYTES_W-1:0] packet_bytes;
    logic [TIME_W-1:0]  arrival_ms;

    modport source (
        output valid, action, header_ok, sequence_req, marker, packet_bytes, arrival_ms,
        input  ready
    );

    modport sink (
        input  valid, action, header_ok, sequence_req, marker, packet_bytes, arrival_ms,
        output ready
    );

endinterface

// ===== sv/rtm_res_if.sv =====
// ---------------------------------------------------------------------------
// RTP monitor result channel
// Valid/ready channel carrying per-packet flags and the running statistics.
// ---------------------------------------------------------------------------
interface rtm_res_if import rtm_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              accepted;
    logic              muted;
    logic              talkspurt_start;
    logic              marker_absent_now;
    logic [LOST_W-1:0] lost_now;
    logic [CNT_W-1:0]  packets_received;
    logic [CNT_W-1:0]  packets_dropped;
    logic [BCNT_W-1:0] bytes_received;
    logic [CNT_W-1:0]  marker_count;
    logic [CNT_W-1:0]  marker_missing_count;

    modport source (
        output valid, accepted, muted, talkspurt_start, marker_absent_now, lost_now,
               packets_received, packets_dropped, bytes_received, marker_count,
               marker_missing_count,
        input  ready
    );

    modport sink (
        input  valid, accepted, muted, talkspurt_start, marker_absent_now, lost_now,
               packets_received, packets_dropped, bytes_received, marker_count,
               marker_missing_count,
        output ready
    );

endinterface

// ===== sv/rtp_talkspurt_loss_monitor.sv =====
// ---------------------------------------------------------------------------
// RTP talkspurt and loss monitor
// Tracks sequence loss, talkspurt boundaries and marker bits of RTP packets.
// ---------------------------------------------------------------------------
// Each item on the pkt channel is one parsed RTP header or a clear request,
// and each one produces exactly one item on the res channel, in order. The
// block sustains one item per clock while the result consumer takes results:
// the front end classifies an item in the cycle it is accepted and writes it
// into a QUEUE_DEPTH-entry queue, and the back end retires one queued item
// per cycle into the tracking state, with the result held in an output
// register. An item passes through the queue and then the output register
// before its result is presented. The back end updates its state (16-bit
// sequence difference, 32-bit silence compare and the saturating 48-bit byte
// add) as each item is retired. When the result consumer stalls, the queue
// absorbs up to QUEUE_DEPTH items before pkt.ready drops.
// Configuration is an APB write port: gap_ms at byte address 0 and
// require_marker at byte address 4; gap_ms resets to 200 ms. Registers are
// meant to be written only while no item is in flight.
// ---------------------------------------------------------------------------
module rtp_talkspurt_loss_monitor import rtm_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    rtm_pkt_if.sink            pkt,
    rtm_res_if.source          res
);

    // Configuration registers. Only paddr[2] selects the register; the low
    // address bits are ignored.
    logic [GAP_W-1:0] gap_ms_reg;
    logic             req_marker_reg;
    logic             cfg_wr;
    logic             reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_ms_reg     <= GAP_MS_RESET;
            req_marker_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_GAP_MS:         gap_ms_reg     <= pwdata[GAP_W-1:0];
                REG_REQUIRE_MARKER: req_marker_reg <= pwdata[0];
                default:            gap_ms_reg     <= gap_ms_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GAP_MS:         prdata = {{(PDATA_W-GAP_W){1'b0}}, gap_ms_reg};
            REG_REQUIRE_MARKER: prdata = {{(PDATA_W-1){1'b0}}, req_marker_reg};
            default:            prdata = '0;
        endcase
    end

    // Front end -> queue -> back end.
    rtm_q_stat_t q_stat;
    logic        push;
    logic        pop;
    rtm_entry_t  push_data;
    rtm_entry_t  head;

    rtm_front u_front (
        .pkt       (pkt),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    rtm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (head),
        .q_stat    (q_stat)
    );

    rtm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .gap_ms         (gap_ms_reg),
        .require_marker (req_marker_reg),
        .q_stat         (q_stat),
        .head           (head),
        .pop            (pop),
        .res            (res)
    );

endmodule

// ===== sv/rtm_front.sv =====
// ---------------------------------------------------------------------------
// RTP monitor front end
// Accepts header items and classifies each as clear, packet or ignored.
// ---------------------------------------------------------------------------
module rtm_front import rtm_pkg::*; (
    rtm_pkt_if.sink    pkt,
    input  rtm_q_stat_t q_stat,
    output logic       push,
    output rtm_entry_t push_data
);

    rtm_op_t op;

    // A clear wins over everything; a bad header still yields a result.
    always_comb
    begin
        if (pkt.action)
        begin
            op = OP_CLEAR;
        end
        else if (pkt.header_ok)
        begin
            op = OP_PACKET;
        end
        else
        begin
            op = OP_IGNORE;
        end
    end

    assign pkt.ready         = !q_stat.full;
    assign push              = pkt.valid && !q_stat.full;
    assign push_data.op      = op;
    assign push_data.seq     = pkt.sequence_req;
    assign push_data.marker  = pkt.marker;
    assign push_data.bytes   = pkt.packet_bytes;
    assign push_data.arrival = pkt.arrival_ms;

endmodule

// ===== sv/rtm_queue.sv =====
// ---------------------------------------------------------------------------
// RTP monitor item queue
// Small register FIFO that decouples classification from the update stage.
// ---------------------------------------------------------------------------
`include "rtp_talkspurt_loss_monitor_assert.svh"

module rtm_queue import rtm_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  rtm_entry_t  push_data,
    input  logic        pop,
    output rtm_entry_t  pop_data,
    output rtm_q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rtm_entry_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (cnt_reg == '0);

    `RTM_ASSERT_NEXT(a_q_fill, clk, rst_n, push && !pop, cnt_reg == $past(cnt_reg) + CNT_W'(1), "queue count did not grow on push")
    `RTM_ASSERT_IMPL(a_q_pop_empty, clk, rst_n, pop, !q_stat.empty, "queue popped while empty")

endmodule

// ===== sv/rtm_back.sv =====
// ---------------------------------------------------------------------------
// RTP monitor back end
// Applies one queued item per cycle, while results are taken, to the tracking state and counters.
// ---------------------------------------------------------------------------
`include "rtp_talkspurt_loss_monitor_assert.svh"

module rtm_back import rtm_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [GAP_W-1:0] gap_ms,
    input  logic             require_marker,
    input  rtm_q_stat_t      q_stat,
    input  rtm_entry_t       head,
    output logic             pop,
    rtm_res_if.source        res
);

    // Tracking state
    logic              seen_reg, seen_next;
    logic [SEQ_W-1:0]  exp_seq_reg, exp_seq_next;
    logic              mute_reg, mute_next;
    logic [TIME_W-1:0] last_arr_reg, last_arr_next;
    logic [CNT_W-1:0]  rcv_reg, rcv_next;
    logic [CNT_W-1:0]  drop_reg, drop_next;
    logic [BCNT_W-1:0] byte_reg, byte_next;
    logic [CNT_W-1:0]  mark_reg, mark_next;
    logic [CNT_W-1:0]  miss_reg, miss_next;

    // Result register
    logic              res_valid_reg;
    logic              acc_reg, acc_next;
    logic              muted_reg, muted_next;
    logic              start_reg, start_next;
    logic              absent_reg, absent_next;
    logic [LOST_W-1:0] lost_reg, lost_next;

    logic [SEQ_W-1:0]  delta;
    logic [LOST_W-1:0] lost;
    logic [TIME_W-1:0] silence;
    logic              boundary;
    logic [CNT_W:0]    drop_sum;
    logic [BCNT_W:0]   byte_sum;

    assign pop = !q_stat.empty && (!res_valid_reg || res.ready);

    assign delta    = head.seq - exp_seq_reg;
    assign lost     = (seen_reg && delta != '0 && delta < SEQ_HALF) ? delta[LOST_W-1:0] : '0;
    assign silence  = head.arrival - last_arr_reg;
    assign boundary = !seen_reg || (silence > {{(TIME_W-GAP_W){1'b0}}, gap_ms});
    assign drop_sum = {1'b0, drop_reg} + (CNT_W+1)'(lost);
    assign byte_sum = {1'b0, byte_reg} + (BCNT_W+1)'(head.bytes);

    always_comb
    begin
        seen_next     = seen_reg;
        exp_seq_next  = exp_seq_reg;
        mute_next     = mute_reg;
        last_arr_next = last_arr_reg;
        rcv_next      = rcv_reg;
        drop_next     = drop_reg;
        byte_next     = byte_reg;
        mark_next     = mark_reg;
        miss_next     = miss_reg;
        acc_next      = 1'b0;
        muted_next    = 1'b0;
        start_next    = 1'b0;
        absent_next   = 1'b0;
        lost_next     = '0;
        case (head.op)
            OP_CLEAR:
            begin
                seen_next     = 1'b0;
                exp_seq_next  = '0;
                mute_next     = 1'b0;
                last_arr_next = '0;
                rcv_next      = '0;
                drop_next     = '0;
                byte_next     = '0;
                mark_next     = '0;
                miss_next     = '0;
            end
            OP_PACKET:
            begin
                drop_next     = drop_sum[CNT_W] ? '1 : drop_sum[CNT_W-1:0];
                exp_seq_next  = head.seq + SEQ_W'(1);
                if (head.marker)
                begin
                    mark_next = (mark_reg == '1) ? mark_reg : mark_reg + CNT_W'(1);
                    mute_next = 1'b0;
                end
                else if (boundary)
                begin
                    absent_next = 1'b1;
                    miss_next   = (miss_reg == '1) ? miss_reg : miss_reg + CNT_W'(1);
                    if (require_marker)
                    begin
                        mute_next = 1'b1;
                    end
                end
                rcv_next      = (rcv_reg == '1) ? rcv_reg : rcv_reg + CNT_W'(1);
                byte_next     = byte_sum[BCNT_W] ? '1 : byte_sum[BCNT_W-1:0];
                last_arr_next = head.arrival;
                seen_next     = 1'b1;
                acc_next      = 1'b1;
                muted_next    = mute_next;
                start_next    = boundary;
                lost_next     = lost;
            end
            default:
            begin
                // Invalid header: state holds, counters are reported as they stand.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            exp_seq_reg   <= '0;
            mute_reg      <= 1'b0;
            last_arr_reg  <= '0;
            rcv_reg       <= '0;
            drop_reg      <= '0;
            byte_reg      <= '0;
            mark_reg      <= '0;
            miss_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                seen_reg     <= seen_next;
                exp_seq_reg  <= exp_seq_next;
                mute_reg     <= mute_next;
                last_arr_reg <= last_arr_next;
                rcv_reg      <= rcv_next;
                drop_reg     <= drop_next;
                byte_reg     <= byte_next;
                mark_reg     <= mark_next;
                miss_reg     <= miss_next;
            end
            if (pop)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            acc_reg    <= acc_next;
            muted_reg  <= muted_next;
            start_reg  <= start_next;
            absent_reg <= absent_next;
            lost_reg   <= lost_next;
        end
    end

    assign res.valid                = res_valid_reg;
    assign res.accepted             = acc_reg;
    assign res.muted                = muted_reg;
    assign res.talkspurt_start      = start_reg;
    assign res.marker_absent_now    = absent_reg;
    assign res.lost_now             = lost_reg;
    assign res.packets_received     = rcv_reg;
    assign res.packets_dropped      = drop_reg;
    assign res.bytes_received       = byte_reg;
    assign res.marker_count         = mark_reg;
    assign res.marker_missing_count = miss_reg;

    `RTM_ASSERT_NEXT(a_clear_zero, clk, rst_n, pop && head.op == OP_CLEAR, !seen_reg && rcv_reg == '0 && byte_reg == '0, "clear did not zero the statistics")
    `RTM_ASSERT_NEXT(a_pkt_seen, clk, rst_n, pop && head.op == OP_PACKET, seen_reg && res.accepted, "packet not recorded as seen")
    `RTM_ASSERT_NEXT(a_pop_result, clk, rst_n, pop, res_valid_reg, "popped item produced no result")

endmodule

// ===== bench/rtp_talkspurt_loss_monitor_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RTP talkspurt and loss monitor testbench
// Drives parsed RTP header items into the monitor under random back-pressure.
// Every accepted item is run through a local tracker that computes the
// expected flags and statistics. Each result item is compared with the oldest
// expectation. Directed tests cover sequence wrap, loss and reordering,
// silence boundaries, marker muting, invalid headers and clears. Random
// talkspurt traffic then runs under several register settings.
// ---------------------------------------------------------------------------
module rtp_talkspurt_loss_monitor_test;
    import rtm_pkg::*;

    // Encoding of the action field of an input item.
    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    // Saturation points of the statistics counters.
    localparam logic [63:0] CNT_MAX  = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] BCNT_MAX = 64'h0000_FFFF_FFFF_FFFF;

    // The run is stopped when this many cycles pass with no handshake at all.
    // The longest quiet stretch of a correct run is made of a sender gap, the
    // pass through the block and a receiver stall.
    localparam int WATCHDOG_LIMIT = 2000;

    // Cycles allowed after the last result.
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic              accepted;
        logic              muted;
        logic              talkspurt_start;
        logic              marker_absent_now;
        logic [LOST_W-1:0] lost_now;
        logic [CNT_W-1:0]  packets_received;
        logic [CNT_W-1:0]  packets_dropped;
        logic [BCNT_W-1:0] bytes_received;
        logic [CNT_W-1:0]  marker_count;
        logic [CNT_W-1:0]  marker_missing_count;
    } monitor_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    rtm_pkt_if pkt_ch ();
    rtm_res_if res_ch ();

    rtp_talkspurt_loss_monitor DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pkt     (pkt_ch),
        .res     (res_ch)
    );

    always #5 clk = ~clk;

    // Local copy of the register settings, updated as each write lands.
    logic [GAP_W-1:0] cfg_gap_ms = GAP_MS_RESET;
    logic             cfg_require_marker = 1'b0;

    // Local copy of the tracking state of the monitor.
    logic              trk_seen;
    logic [SEQ_W-1:0]  trk_next_seq;
    logic              trk_mute;
    logic [TIME_W-1:0] trk_last_arrival;
    logic [63:0]       trk_received;
    logic [63:0]       trk_dropped;
    logic [63:0]       trk_bytes;
    logic [63:0]       trk_marks;
    logic [63:0]       trk_missing;

    // Results predicted for accepted items, oldest first.
    monitor_result_t expected_results[$];

    int  error_count = 0;
    int  quiet_cycles = 0;
    // When low, both sides run without gaps or stalls.
    bit  idle_on = 1'b1;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] max);
        logic [63:0] sum;
        sum = a + b;
        return (sum > max) ? max : sum;
    endfunction

    // A clear returns every piece of tracking state to zero, as reset does.
    task automatic clear_tracker();
        trk_seen         = 1'b0;
        trk_next_seq     = '0;
        trk_mute         = 1'b0;
        trk_last_arrival = '0;
        trk_received     = '0;
        trk_dropped      = '0;
        trk_bytes        = '0;
        trk_marks        = '0;
        trk_missing      = '0;
    endtask

    // Applies one accepted item to the local tracker and returns the result
    // that the monitor must produce for it.
    task automatic predict_result(input logic action, input logic header_ok,
                                  input logic [SEQ_W-1:0] seq, input logic marker,
                                  input logic [BYTES_W-1:0] bytes,
                                  input logic [TIME_W-1:0] arrival,
                                  output monitor_result_t r);
        logic [SEQ_W-1:0]  delta;
        logic [TIME_W-1:0] silence;
        logic              boundary;
        r = '0;
        if (action == ACT_CLEAR) begin
            clear_tracker();
        end else if (header_ok) begin
            // Forward gaps below half the sequence space are losses; larger
            // differences are taken as reordering and are not counted.
            delta = seq - trk_next_seq;
            if (trk_seen && delta != '0 && delta < SEQ_HALF) begin
                r.lost_now  = delta[LOST_W-1:0];
                trk_dropped = sat_add(trk_dropped, 64'(delta), CNT_MAX);
            end
            trk_next_seq = seq + 1'b1;

            // The silence wraps modulo 2^32 and must exceed gap_ms.
            silence  = arrival - trk_last_arrival;
            boundary = !trk_seen || (silence > TIME_W'(cfg_gap_ms));

            if (marker) begin
                trk_marks = sat_add(trk_marks, 64'd1, CNT_MAX);
                trk_mute  = 1'b0;
            end else if (boundary) begin
                r.marker_absent_now = 1'b1;
                trk_missing = sat_add(trk_missing, 64'd1, CNT_MAX);
                if (cfg_require_marker)
                    trk_mute = 1'b1;
            end

            trk_received     = sat_add(trk_received, 64'd1, CNT_MAX);
            trk_bytes        = sat_add(trk_bytes, 64'(bytes), BCNT_MAX);
            trk_last_arrival = arrival;
            trk_seen         = 1'b1;

            r.accepted        = 1'b1;
            r.muted           = trk_mute;
            r.talkspurt_start = boundary;
        end
        // Invalid headers leave the state alone and report the counters as
        // they stand; a clear reports them at zero.
        r.packets_received     = trk_received[CNT_W-1:0];
        r.packets_dropped      = trk_dropped[CNT_W-1:0];
        r.bytes_received       = trk_bytes[BCNT_W-1:0];
        r.marker_count         = trk_marks[CNT_W-1:0];
        r.marker_missing_count = trk_missing[CNT_W-1:0];
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] expv,
                                   input logic [63:0] actv);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, field, expv, actv);
    endtask

    // Sends one item. The task is entered just after a falling edge and
    // returns just after the falling edge that follows the handshake, with
    // valid still high so that a back-to-back item follows without a gap.
    task automatic send_item(input logic action, input logic header_ok,
                             input logic [SEQ_W-1:0] seq, input logic marker,
                             input logic [BYTES_W-1:0] bytes,
                             input logic [TIME_W-1:0] arrival);
        int              gap;
        monitor_result_t predicted;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            pkt_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pkt_ch.action       <= action;
        pkt_ch.header_ok    <= header_ok;
        pkt_ch.sequence_req <= seq;
        pkt_ch.marker       <= marker;
        pkt_ch.packet_bytes <= bytes;
        pkt_ch.arrival_ms   <= arrival;
        pkt_ch.valid        <= 1'b1;
        do
            @(posedge clk);
        while (pkt_ch.ready !== 1'b1);
        predict_result(action, header_ok, seq, marker, bytes, arrival, predicted);
        expected_results.push_back(predicted);
        @(negedge clk);
    endtask

    // Lowers valid and holds the sender back until every result is in.
    task automatic drain_results();
        pkt_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // APB write: a setup phase, then an access phase that completes at the
    // rising edge where pready is high. The block is drained first so that
    // no item is in flight when the register changes.
    task automatic write_register(input logic index, input logic [PDATA_W-1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (index == REG_GAP_MS)
            cfg_gap_ms = value[GAP_W-1:0];
        else
            cfg_require_marker = value[0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [GAP_W-1:0] gap, input logic require_marker);
        write_register(REG_GAP_MS, PDATA_W'(gap));
        write_register(REG_REQUIRE_MARKER, PDATA_W'(require_marker));
    endtask

    // Talkspurt boundaries from silence, with the reset gap of 200 ms and
    // then the smallest and largest gap settings. The first two packets also
    // wrap the sequence number and the arrival time.
    task automatic test_silence_boundaries();
        send_item(ACT_PACKET, 1'b1, 16'hFFFF, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);
        // 199 - 0xFFFFFFFF wraps to exactly 200 ms, which is not a boundary.
        send_item(ACT_PACKET, 1'b1, 16'h0000, 1'b1, 16'h0000, 32'd199);
        send_item(ACT_PACKET, 1'b1, 16'h0001, 1'b0, 16'd100, 32'd400);
        set_config(16'd0, 1'b0);
        send_item(ACT_PACKET, 1'b1, 16'h0002, 1'b0, 16'd160, 32'd400);
        send_item(ACT_PACKET, 1'b1, 16'h0003, 1'b1, 16'd160, 32'd401);
        set_config(16'hFFFF, 1'b0);
        send_item(ACT_PACKET, 1'b1, 16'h0004, 1'b0, 16'd172, 32'd65936);
        send_item(ACT_PACKET, 1'b1, 16'h0005, 1'b0, 16'd172, 32'd131472);
    endtask

    // Loss counting: a small gap, the largest gap still counted as loss,
    // a half-space jump taken as reordering, a backward step and an in-order
    // packet. The arrival time stays fixed so no boundary interferes.
    task automatic test_sequence_gaps();
        send_item(ACT_PACKET, 1'b1, 16'h000A, 1'b0, 16'd200, 32'd131472);
        send_item(ACT_PACKET, 1'b1, 16'h800A, 1'b1, 16'd200, 32'd131472);
        send_item(ACT_PACKET, 1'b1, 16'h000B, 1'b0, 16'd200, 32'd131472);
        send_item(ACT_PACKET, 1'b1, 16'h0003, 1'b0, 16'd200, 32'd131472);
        send_item(ACT_PACKET, 1'b1, 16'h0004, 1'b0, 16'd200, 32'd131472);
    endtask

    // Muting: with require_marker set, a boundary without marker mutes the
    // talkspurt until a marked packet arrives. The mute also outlives a
    // switch back to require_marker off, until the next marker.
    task automatic test_marker_mute();
        set_config(GAP_MS_RESET, 1'b1);
        send_item(ACT_CLEAR, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(ACT_PACKET, 1'b1, 16'd100, 1'b0, 16'd172, 32'd1000);
        send_item(ACT_PACKET, 1'b1, 16'd101, 1'b0, 16'd172, 32'd1010);
        send_item(ACT_PACKET, 1'b1, 16'd102, 1'b1, 16'd172, 32'd1020);
        send_item(ACT_PACKET, 1'b1, 16'd103, 1'b0, 16'd172, 32'd1500);
        set_config(GAP_MS_RESET, 1'b0);
        send_item(ACT_PACKET, 1'b1, 16'd104, 1'b0, 16'd172, 32'd1510);
        send_item(ACT_PACKET, 1'b1, 16'd105, 1'b1, 16'd172, 32'd1520);
        send_item(ACT_PACKET, 1'b1, 16'd106, 1'b0, 16'd172, 32'd2000);
    endtask

    // Invalid headers with extreme contents change nothing; a clear with
    // the header flag low still clears, and the packet after it is a
    // boundary that counts no loss.
    task automatic test_invalid_and_clear();
        send_item(ACT_PACKET, 1'b0, 16'hFFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(ACT_PACKET, 1'b0, 16'h0000, 1'b0, 16'h0000, 32'h0000_0000);
        send_item(ACT_CLEAR, 1'b0, 16'h0000, 1'b0, 16'h0000, 32'h0000_0000);
        send_item(ACT_PACKET, 1'b1, 16'h1234, 1'b1, 16'd1500, 32'd5);
    endtask

    // Random talkspurt traffic in five phases with different settings.
    // Most items continue a plausible stream: mostly in-order sequence
    // numbers, some losses and reordering, short arrival steps within the
    // gap and occasional silences past it. The rest are clears, invalid
    // headers and fully random packets.
    task automatic test_random_traffic();
        logic [SEQ_W-1:0]  next_seq;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] now;
        logic              jump;
        logic              marker;
        int                pick;
        next_seq = SEQ_W'($urandom);
        now      = $urandom;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       set_config(GAP_MS_RESET, 1'b0);
                1:       set_config(16'd0, 1'b1);
                2:       set_config(16'hFFFF, 1'b1);
                3:       set_config(GAP_W'($urandom_range(1, 1000)), 1'b1);
                default: set_config(GAP_W'($urandom_range(0, 16'hFFFF)), 1'b0);
            endcase
            for (int n = 0; n < 90; n++) begin
                // Every thirty items the idling is switched, leaving some
                // stretches that run at full rate on both sides.
                if (n % 30 == 0)
                    idle_on = ($urandom_range(0, 2) != 0);
                // Midway through each phase the sender waits for the block
                // to empty completely before going on.
                if (n == 45)
                    drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    send_item(ACT_CLEAR, 1'($urandom), SEQ_W'($urandom), 1'($urandom),
                              BYTES_W'($urandom), $urandom);
                end else if (pick < 12) begin
                    send_item(ACT_PACKET, 1'($urandom), SEQ_W'($urandom), 1'($urandom),
                              BYTES_W'($urandom), $urandom);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 80)
                        seq = next_seq;
                    else if (pick < 92)
                        seq = next_seq + SEQ_W'($urandom_range(1, 4));
                    else if (pick < 96)
                        seq = next_seq + SEQ_W'($urandom_range(5, 16'h7FFF));
                    else
                        seq = next_seq + SEQ_W'($urandom_range(16'h8000, 16'hFFFF));
                    next_seq = seq + 1'b1;
                    jump = ($urandom_range(0, 7) == 0);
                    if (jump && $urandom_range(0, 9) == 0)
                        now = now + $urandom;
                    else if (jump)
                        now = now + TIME_W'(cfg_gap_ms) + 32'd1 + $urandom_range(0, 500);
                    else
                        now = now + $urandom_range(0, 32'(cfg_gap_ms));
                    // Talkspurts usually open with the marker and rarely carry
                    // it elsewhere.
                    marker = jump ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0);
                    send_item(ACT_PACKET, 1'b1, seq, marker, BYTES_W'($urandom), now);
                end
            end
        end
        idle_on = 1'b1;
    endtask

    // Result side: a random stall before each result, then ready stays high
    // until a result is taken. Each taken result is checked against the
    // oldest prediction.
    initial begin
        int              stall;
        monitor_result_t actual;
        monitor_result_t predicted;
        res_ch.ready = 1'b0;
        forever begin
            stall = idle_on ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (res_ch.valid !== 1'b1);
            actual.accepted             = res_ch.accepted;
            actual.muted                = res_ch.muted;
            actual.talkspurt_start      = res_ch.talkspurt_start;
            actual.marker_absent_now    = res_ch.marker_absent_now;
            actual.lost_now             = res_ch.lost_now;
            actual.packets_received     = res_ch.packets_received;
            actual.packets_dropped      = res_ch.packets_dropped;
            actual.bytes_received       = res_ch.bytes_received;
            actual.marker_count         = res_ch.marker_count;
            actual.marker_missing_count = res_ch.marker_missing_count;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result item arrived with no item pending", $time);
            end else begin
                predicted = expected_results.pop_front();
                if (actual.accepted !== predicted.accepted)
                    report_mismatch("accepted", 64'(predicted.accepted),
                                    64'(actual.accepted));
                if (actual.muted !== predicted.muted)
                    report_mismatch("muted", 64'(predicted.muted), 64'(actual.muted));
                if (actual.talkspurt_start !== predicted.talkspurt_start)
                    report_mismatch("talkspurt_start", 64'(predicted.talkspurt_start),
                                    64'(actual.talkspurt_start));
                if (actual.marker_absent_now !== predicted.marker_absent_now)
                    report_mismatch("marker_absent_now", 64'(predicted.marker_absent_now),
                                    64'(actual.marker_absent_now));
                if (actual.lost_now !== predicted.lost_now)
                    report_mismatch("lost_now", 64'(predicted.lost_now),
                                    64'(actual.lost_now));
                if (actual.packets_received !== predicted.packets_received)
                    report_mismatch("packets_received", 64'(predicted.packets_received),
                                    64'(actual.packets_received));
                if (actual.packets_dropped !== predicted.packets_dropped)
                    report_mismatch("packets_dropped", 64'(predicted.packets_dropped),
                                    64'(actual.packets_dropped));
                if (actual.bytes_received !== predicted.bytes_received)
                    report_mismatch("bytes_received", 64'(predicted.bytes_received),
                                    64'(actual.bytes_received));
                if (actual.marker_count !== predicted.marker_count)
                    report_mismatch("marker_count", 64'(predicted.marker_count),
                                    64'(actual.marker_count));
                if (actual.marker_missing_count !== predicted.marker_missing_count)
                    report_mismatch("marker_missing_count",
                                    64'(predicted.marker_missing_count),
                                    64'(actual.marker_missing_count));
            end
            @(negedge clk);
        end
    end

    // Watchdog: any handshake on either channel or the register port counts
    // as progress; a long quiet stretch means the block has hung.
    always @(posedge clk) begin
        if ((pkt_ch.valid === 1'b1 && pkt_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
            (psel === 1'b1 && penable === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("rtp_talkspurt_loss_monitor_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence: reset once, the directed tests, the random traffic,
    // then wait for the last results and give the verdict.
    initial begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        pkt_ch.valid        = 1'b0;
        pkt_ch.action       = ACT_PACKET;
        pkt_ch.header_ok    = 1'b0;
        pkt_ch.sequence_req = '0;
        pkt_ch.marker       = 1'b0;
        pkt_ch.packet_bytes = '0;
        pkt_ch.arrival_ms   = '0;
        clear_tracker();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_silence_boundaries();
        test_sequence_gaps();
        test_marker_mute();
        test_invalid_and_clear();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("rtp_talkspurt_loss_monitor_test OK");
        else
            $display("rtp_talkspurt_loss_monitor_test NOT OK");
        $finish;
    end

endmodule
